/* hw/rtl/tsdd_pkg.sv */
// ----------------------------------------------------------------------------
// tsdd_pkg
// Shared types, constants and register indexes of the target select core.
// ----------------------------------------------------------------------------
package tsdd_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;

   localparam logic [15:0] W_CONF = 16'd39322;
   localparam logic [15:0] W_PROX = 16'd26214;
   localparam logic [15:0] W_OLD  = 16'd45875;
   localparam logic [15:0] W_NEW  = 16'd19661;

   typedef enum logic [1:0] {
      OP_DET  = 2'd0,
      OP_EOF  = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_CLASS = 3'd0,
      REG_THR   = 3'd1,
      REG_TOL   = 3'd2,
      REG_WIDTH = 3'd3,
      REG_HEIGHT = 3'd4,
      REG_PULSE = 3'd5,
      REG_LOST  = 3'd6
   } reg_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture input beat, compute pixels
      logic dist_start;  // start distance root
      logic diag_start;  // start diagonal root
      logic div_start;   // start proximity divide
      logic score;       // compute score
      logic commit;      // apply op to state, build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic unit_done;
      logic need_prox;   // detection that passes and a track is held
      logic diag_zero;
   } sts_type;

endpackage

/* hw/rtl/tsdd_ctrl.sv */
// ----------------------------------------------------------------------------
// tsdd_ctrl
// Sequencer: steps one input beat through load, roots, divide, score and commit.
// ----------------------------------------------------------------------------
module tsdd_ctrl
   import tsdd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_free,
   input  sts_type sts,
   output logic    req_ready,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_CHECK = 8'b00000010,
      S_DIST  = 8'b00000100,
      S_DIAG  = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_SCORE = 8'b00100000,
      S_WAIT  = 8'b01000000,
      S_COMMIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.need_prox) begin
               cmd.dist_start = 1'b1;
               state_in = S_DIST;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_DIST: begin
            if (sts.unit_done) begin
               cmd.diag_start = 1'b1;
               state_in = S_DIAG;
            end
         end
         S_DIAG: begin
            if (sts.unit_done) begin
               if (sts.diag_zero) begin
                  state_in = S_SCORE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (sts.unit_done) state_in = S_SCORE;
         end
         S_SCORE: begin
            cmd.score = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_free) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.dist_start, cmd.diag_start, cmd.div_start,
                cmd.score, cmd.commit}))
      else $error("more than one command");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(rsp_free))
      else $error("commit without room");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("accepted while busy");

endmodule

/* hw/rtl/tsdd_datapath.sv */
// ----------------------------------------------------------------------------
// tsdd_datapath
// Registers, pixel scaling, shared root/divide unit, score and frame state.
// ----------------------------------------------------------------------------
module tsdd_datapath
   import tsdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [1:0]  in_op,
   input  logic [7:0]  in_class,
   input  logic [15:0] in_conf,
   input  logic [15:0] in_left,
   input  logic [15:0] in_top,
   input  logic [15:0] in_right,
   input  logic [15:0] in_bottom,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [47:0] rsp_data
);

   localparam logic [COORD_BITS-1:0] PIX_MAX = '1;

   // configuration
   logic [7:0]  class_ff;
   logic [15:0] thr_ff;
   logic [10:0] tol_ff;
   logic [11:0] width_ff, height_ff;
   logic [15:0] pulse_ff;
   logic [7:0]  maxlost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= 8'd0;    thr_ff <= 16'd32768; tol_ff <= 11'd50;
         width_ff <= 12'd640; height_ff <= 12'd480; pulse_ff <= 16'd100;
         maxlost_ff <= 8'd10;
      end else if (csr_we) begin
         case (csr_index)
            REG_CLASS:  class_ff   <= csr_wdata[7:0];
            REG_THR:    thr_ff     <= csr_wdata;
            REG_TOL:    tol_ff     <= csr_wdata[10:0];
            REG_WIDTH:  width_ff   <= csr_wdata[11:0];
            REG_HEIGHT: height_ff  <= csr_wdata[11:0];
            REG_PULSE:  pulse_ff   <= csr_wdata;
            REG_LOST:   maxlost_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // track and frame state
   logic signed [12:0] last_x_ff, last_y_ff, best_x_ff, best_y_ff;
   logic [7:0]  lost_ff;
   logic [16:0] best_score_ff;
   logic [15:0] best_conf_ff;
   logic        hit_ff;
   logic [15:0] elapsed_ff [4];
   logic [3:0]  relay_ff;

   // captured beat
   logic [1:0]  op_ff;
   logic        pass_ff;
   logic [15:0] conf_ff;
   logic signed [12:0] cx_ff, cy_ff;

   function automatic logic [COORD_BITS-1:0] to_pix(logic [15:0] n, logic [11:0] s);
      logic [27:0] p;
      p = (28'(n) * 28'(s)) >> FRAC_BITS;
      return (p > 28'(PIX_MAX)) ? PIX_MAX : p[COORD_BITS-1:0];
   endfunction

   logic [COORD_BITS:0] sx, sy;
   assign sx = {1'b0, to_pix(in_left, width_ff)}  + {1'b0, to_pix(in_right, width_ff)};
   assign sy = {1'b0, to_pix(in_top, height_ff)} + {1'b0, to_pix(in_bottom, height_ff)};

   logic held;
   assign held = (last_x_ff > 13'sd0) && (last_y_ff > 13'sd0);

   // shared iterative unit: root (2 bits/step) or restoring divide (1 bit/step)
   logic [31:0] rv_ff, rres_ff, rbit_ff;
   logic        busy_ff, isdiv_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] dist_ff, diag_ff;
   logic [32:0] num_ff;     // dividend shift register
   logic [16:0] rem_ff;
   logic [32:0] quo_ff;
   logic [16:0] prox_ff;
   logic        done_ff;

   logic signed [13:0] dx, dy;
   assign dx = 14'(cx_ff) - 14'(last_x_ff);
   assign dy = 14'(cy_ff) - 14'(last_y_ff);
   logic [27:0] d2;
   assign d2 = 28'(dx * dx) + 28'(dy * dy);
   logic [24:0] g2;
   assign g2 = 25'(width_ff * width_ff) + 25'(height_ff * height_ff);

   logic [31:0] rsum;
   assign rsum = rres_ff + rbit_ff;
   logic [17:0] rtry;
   assign rtry = {rem_ff, num_ff[32]} - {2'b0, diag_ff};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.dist_start || cmd.diag_start) begin
         busy_ff <= 1'b1; isdiv_ff <= 1'b0;
         rv_ff   <= cmd.dist_start ? 32'(d2) : 32'(g2);
         rres_ff <= '0; rbit_ff <= 32'h4000_0000; cnt_ff <= 5'd15;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1; isdiv_ff <= 1'b1;
         // 32 steps consume bits 32..1: dist << 16
         num_ff <= {dist_ff, 17'd0}; rem_ff <= '0; quo_ff <= '0;
         cnt_ff <= 5'd31;
      end else if (busy_ff) begin
         if (!isdiv_ff) begin
            if (rv_ff >= rsum) begin
               rv_ff <= rv_ff - rsum; rres_ff <= (rres_ff >> 1) + rbit_ff;
            end else begin
               rres_ff <= rres_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
         end else begin
            if (!rtry[17]) begin
               rem_ff <= rtry[16:0]; quo_ff <= {quo_ff[31:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[15:0], num_ff[32]}; quo_ff <= {quo_ff[31:0], 1'b0};
            end
            num_ff <= {num_ff[31:0], 1'b0};
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
         end
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   // result of a finished root lands in dist or diag
   logic root_which_ff;   // 0 dist, 1 diag
   always_ff @(posedge clock) begin
      if (cmd.dist_start) root_which_ff <= 1'b0;
      if (cmd.diag_start) root_which_ff <= 1'b1;
      if (done_ff && !isdiv_ff) begin
         if (root_which_ff) diag_ff <= rres_ff[15:0];
         else               dist_ff <= rres_ff[15:0];
      end
      if (cmd.diag_start) prox_ff <= 17'h10000;   // zero diagonal keeps full scale
      if (done_ff && isdiv_ff)
         prox_ff <= (quo_ff >= 33'h10000) ? 17'd0 : 17'h10000 - quo_ff[16:0];
   end

   // diag_ff is written the same edge done is seen; peek the root directly
   assign sts.unit_done = done_ff;
   assign sts.diag_zero = (rres_ff[15:0] == 16'd0);
   assign sts.need_prox = pass_ff && held && (op_ff == OP_DET);

   logic [32:0] score_full;
   assign score_full = 33'(conf_ff * W_CONF) + 33'(prox_ff * W_PROX);
   logic [16:0] score_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_op;
         conf_ff <= in_conf;
         pass_ff <= (in_conf > thr_ff) && (in_class == class_ff);
         cx_ff   <= 13'(sx >> 1);
         cy_ff   <= 13'(sy >> 1);
         score_ff <= {1'b0, in_conf};
      end else if (cmd.score) begin
         score_ff <= score_full[32:16];
      end
   end

   // frame end smoothing and dead zone
   logic [28:0] smx, smy;
   assign smx = 29'(13'(last_x_ff) * W_OLD) + 29'(13'(best_x_ff) * W_NEW);
   assign smy = 29'(13'(last_y_ff) * W_OLD) + 29'(13'(best_y_ff) * W_NEW);
   logic signed [13:0] nx, ny, mx, my, tt;
   assign nx = held ? 14'(smx[28:16]) : 14'(best_x_ff);
   assign ny = held ? 14'(smy[28:16]) : 14'(best_y_ff);
   assign mx = 14'(width_ff >> 1);
   assign my = 14'(height_ff >> 1);
   assign tt = 14'(tol_ff);

   logic [3:0] fire;
   always_comb begin
      fire = 4'b0;
      if (nx < mx - tt)      fire[1] = 1'b1;
      else if (nx > mx + tt) fire[0] = 1'b1;
      if (ny < my - tt)      fire[2] = 1'b1;
      else if (ny > my + tt) fire[3] = 1'b1;
   end

   logic [7:0] lost_inc;
   assign lost_inc = (lost_ff == 8'hFF) ? lost_ff : lost_ff + 8'd1;

   logic        found_ff;
   logic [15:0] conf_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= -13'sd1; last_y_ff <= -13'sd1; lost_ff <= '0;
         best_score_ff <= '0; best_x_ff <= -13'sd1; best_y_ff <= -13'sd1;
         best_conf_ff <= '0; hit_ff <= 1'b0; relay_ff <= '0;
         for (int k = 0; k < 4; k++) elapsed_ff[k] <= '0;
         rsp_valid <= 1'b0; found_ff <= 1'b0; conf_out_ff <= '0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (cmd.commit) begin
            rsp_valid <= 1'b1;
            found_ff  <= 1'b0;
            conf_out_ff <= best_conf_ff;
            case (op_ff)
               OP_DET: begin
                  if (pass_ff && score_ff > best_score_ff) begin
                     best_score_ff <= score_ff; best_conf_ff <= conf_ff;
                     best_x_ff <= cx_ff; best_y_ff <= cy_ff; hit_ff <= 1'b1;
                     conf_out_ff <= conf_ff;
                  end
               end
               OP_EOF: begin
                  conf_out_ff <= hit_ff ? best_conf_ff : 16'd0;
                  if (hit_ff) begin
                     found_ff <= 1'b1; lost_ff <= '0;
                     last_x_ff <= 13'(nx); last_y_ff <= 13'(ny);
                     for (int k = 0; k < 4; k++)
                        if (fire[k]) begin
                           relay_ff[k] <= 1'b1; elapsed_ff[k] <= '0;
                        end
                  end else begin
                     lost_ff <= lost_inc;
                     if (lost_inc > maxlost_ff) begin
                        last_x_ff <= -13'sd1; last_y_ff <= -13'sd1;
                     end
                  end
                  best_score_ff <= '0; best_x_ff <= -13'sd1; best_y_ff <= -13'sd1;
                  best_conf_ff <= '0; hit_ff <= 1'b0;
               end
               OP_TICK: begin
                  for (int k = 0; k < 4; k++)
                     if (relay_ff[k]) begin
                        if (elapsed_ff[k] != 16'hFFFF) elapsed_ff[k] <= elapsed_ff[k] + 16'd1;
                        if (((elapsed_ff[k] == 16'hFFFF) ? elapsed_ff[k]
                             : elapsed_ff[k] + 16'd1) >= pulse_ff) relay_ff[k] <= 1'b0;
                     end
               end
               default: ;
            endcase
         end
      end
   end

   // {best_confidence, relay_mask, target_y, target_x, tracking, target_found}
   assign rsp_data = {conf_out_ff, relay_ff, last_y_ff, last_x_ff,
                      (last_x_ff > 13'sd0), found_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && !cmd.commit) |=> rsp_valid)
      else $error("result dropped");
   a_commit_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten");
   a_lost_reset: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_EOF && hit_ff) |=> lost_ff == 8'd0)
      else $error("lost count not cleared");

endmodule

/* hw/rtl/target_select_deadzone_drive_core.sv */
// ----------------------------------------------------------------------------
// target_select_deadzone_drive_core
// Picks the best detection per frame, smooths it and drives four relays.
// ----------------------------------------------------------------------------
// Input beats on req_ carry a detection, a frame end or a millisecond tick
// (op in tuser). Each input beat yields exactly one result beat on rsp_.
// A frame end, a tick or a detection that needs no proximity passes from accept
// through the check, wait and commit states to rsp_tvalid. A detection scored
// against a held track first runs two square roots (16 steps each) and, unless
// the diagonal is zero, a 32-step divide in one shared iterative unit. The next
// beat is taken only once the result is registered, so a new beat is never
// accepted while the root and divide unit is busy with the last one.
// The result sits in an output register; the core stalls only when that
// register is still full while rsp_tready is low.
// Reset (synchronous, high) restores default registers, drops the track and
// switches all relays off. csr_ writes take effect at once; make them only
// while idle, the core itself does not enforce this.
// ----------------------------------------------------------------------------
module target_select_deadzone_drive_core
   import tsdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // class_id, confidence, left, top, right, bottom
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // found, tracking, x, y, relay_mask, best_conf
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tsdd_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req_tvalid && req_tready),
      .rsp_free (!rsp_tvalid || rsp_tready),
      .sts, .req_ready (req_tready), .cmd
   );

   tsdd_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .csr_we, .csr_index, .csr_wdata,
      .in_op     (req_tuser),
      .in_class  (req_tdata[7:0]),
      .in_conf   (req_tdata[23:8]),
      .in_left   (req_tdata[39:24]),
      .in_top    (req_tdata[55:40]),
      .in_right  (req_tdata[71:56]),
      .in_bottom (req_tdata[87:72]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata)
   );

endmodule
